// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// plain condition checked at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// File: src/srtq_pkg.sv
// ----------------------------------------------------------------------------
// srtq_pkg
// shared types and constants of the sequenced ring task queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srtq_pkg;

    localparam int MAX_DEPTH_DEF   = 1024;
    localparam int SIZE_LOG2_CAP   = 10;
    localparam int POS_W           = 64;
    localparam int HANDLE_W        = 64;

    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

    // request codes
    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DEQ   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP
    } state_t;

endpackage

// File: src/sequenced_ring_task_queue_top.sv
// ----------------------------------------------------------------------------
// sequenced_ring_task_queue_top
// bounded ring queue of task entries, each cell guarded by a sequence stamp
// ----------------------------------------------------------------------------
//
// channel   dir   handshake              payload
// s_*       in    s_tvalid / s_tready    tuser: req_type; tdata: proc, data
// m_*       out   m_tvalid / m_tready    tuser: ok; tdata: id, proc, data
// cfg_*     in    cfg_valid / cfg_ready  cfg_data: size_log2
//
// an enqueue, dequeue or ignored request is accepted with the stamp and
// entry memory reads, then compared and written back; the stamp memory
// read is synchronous, so its result is registered before the compare
// a flush or a size_log2 write adds a stamp sweep over cells 0 to mask (one cell
// a cycle); after reset the sweep covers 2^max(2, min(10, floor(log2(MAX_DEPTH)))) cells
// no request is accepted during a sweep; configuration writes are always taken
// a request is accepted while a result waits; it then holds in the compare
// stage until the output register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sequenced_ring_task_queue_top #(
    parameter int MAX_DEPTH = srtq_pkg::MAX_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] proc_handle, [127:64] data_handle
    input  logic [1:0]   s_tuser,   // [1:0] req_type
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // [63:0] task_id, [127:64] task_proc,
                                    // [191:128] task_data
    output logic [0:0]   m_tuser,   // [0] ok
    // configuration channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data   // size_log2
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);
    // largest usable log2 of the ring size
    localparam int LG_FLOOR = $clog2(MAX_DEPTH + 1) - 1;
    localparam int LG_LIM   = (LG_FLOOR < srtq_pkg::SIZE_LOG2_CAP) ?
                              LG_FLOOR : srtq_pkg::SIZE_LOG2_CAP;
    localparam int PW  = srtq_pkg::POS_W;
    localparam int HW  = srtq_pkg::HANDLE_W;
    localparam int EW  = PW + 2 * HW;

    // clamp size_log2 and turn it into a slot mask
    function automatic logic [ADDR_W-1:0] mask_of(input logic [3:0] lg_in);
        logic [4:0]      lg;
        logic [ADDR_W:0] one;
        logic [ADDR_W:0] msk;
        lg = {1'b0, lg_in};
        if (lg < 5'd2)
        begin
            lg = 5'd2;
        end
        if (lg > 5'(LG_LIM))
        begin
            lg = 5'(LG_LIM);
        end
        one = {{ADDR_W{1'b0}}, 1'b1} << lg;
        msk = one - {{ADDR_W{1'b0}}, 1'b1};
        return msk[ADDR_W-1:0];
    endfunction

    // state and control registers
    srtq_pkg::state_t  state_reg, state_next;
    logic [PW-1:0]     wpos_reg, wpos_next;
    logic [PW-1:0]     rpos_reg, rpos_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    // payload registers
    logic [1:0]        req_reg;
    logic [HW-1:0]     proc_reg;
    logic [HW-1:0]     data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [EW-1:0]     m_data_reg, m_data_next;
    logic              m_ok_reg, m_ok_next;

    // memories: stamps, and entries packed as {data, proc, id}
    logic [PW-1:0] stamp_mem [MAX_DEPTH];
    logic [EW-1:0] entry_mem [MAX_DEPTH];
    logic [PW-1:0] stamp_q;
    logic [EW-1:0] entry_q;

    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    logic              stamp_we;
    logic [ADDR_W-1:0] stamp_waddr;
    logic [PW-1:0]     stamp_wdata;
    logic              entry_we;
    logic              out_free;
    logic              enq_hit;
    logic              deq_hit;
    logic [PW-1:0]     mask_ext;
    logic [PW-1:0]     rpos_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == srtq_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign mask_ext  = {{(PW - ADDR_W){1'b0}}, mask_reg};
    assign rpos_inc  = rpos_reg + {{(PW - 1){1'b0}}, 1'b1};
    assign enq_hit   = (stamp_q == wpos_reg);
    assign deq_hit   = (stamp_q == rpos_inc);

    // slot under the position that the request uses
    assign rd_addr = (s_tuser == srtq_pkg::REQ_DEQ) ? (rpos_reg[ADDR_W-1:0] & mask_reg)
                                                    : (wpos_reg[ADDR_W-1:0] & mask_reg);

    // stamp memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        if (accept)
        begin
            stamp_q <= stamp_mem[rd_addr];
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[addr_reg] <= {data_reg, proc_reg, ~wpos_reg};
        end
        if (accept)
        begin
            entry_q <= entry_mem[rd_addr];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            proc_reg <= s_tdata[HW-1:0];
            data_reg <= s_tdata[2*HW-1:HW];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srtq_pkg::ST_SWEEP;
            wpos_reg    <= '0;
            rpos_reg    <= '0;
            mask_reg    <= mask_of(srtq_pkg::SIZE_LOG2_RESET);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            rpos_reg    <= rpos_next;
            mask_reg    <= mask_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_ok_reg   <= m_ok_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        rpos_next    = rpos_reg;
        mask_next    = mask_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_ok_next    = m_ok_reg;
        stamp_we     = 1'b0;
        stamp_waddr  = addr_reg;
        stamp_wdata  = '0;
        entry_we     = 1'b0;

        unique case (state_reg)
            srtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = srtq_pkg::ST_LOOK;
                end
            end
            srtq_pkg::ST_LOOK:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_ok_next    = 1'b0;
                    m_data_next  = '0;
                    state_next   = srtq_pkg::ST_IDLE;
                    unique case (req_reg)
                        srtq_pkg::REQ_ENQ:
                        begin
                            if (enq_hit)
                            begin
                                stamp_we    = 1'b1;
                                stamp_wdata = wpos_reg + {{(PW - 1){1'b0}}, 1'b1};
                                entry_we    = 1'b1;
                                wpos_next   = stamp_wdata;
                                m_ok_next   = 1'b1;
                                m_data_next = {{(2 * HW){1'b0}}, ~wpos_reg};
                            end
                        end
                        srtq_pkg::REQ_DEQ:
                        begin
                            if (deq_hit)
                            begin
                                // hand the cell on to the next lap of writers
                                stamp_we    = 1'b1;
                                stamp_wdata = rpos_inc + mask_ext;
                                rpos_next   = rpos_inc;
                                m_ok_next   = 1'b1;
                                m_data_next = entry_q;
                            end
                        end
                        srtq_pkg::REQ_FLUSH:
                        begin
                            m_ok_next  = 1'b1;
                            wpos_next  = '0;
                            rpos_next  = '0;
                            cnt_next   = '0;
                            state_next = srtq_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            // unused code: empty result, no state change
                        end
                    endcase
                end
            end
            srtq_pkg::ST_SWEEP:
            begin
                // restamp each cell in use with its own index
                stamp_we    = 1'b1;
                stamp_waddr = cnt_reg;
                stamp_wdata = {{(PW - ADDR_W){1'b0}}, cnt_reg};
                if (cnt_reg == mask_reg)
                begin
                    state_next = srtq_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + {{(ADDR_W - 1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                state_next = srtq_pkg::ST_SWEEP;
                cnt_next   = '0;
            end
        endcase

        // a size write flushes the ring and restarts the sweep
        if (cfg_valid && cfg_ready)
        begin
            mask_next  = mask_of(cfg_data);
            wpos_next  = '0;
            rpos_next  = '0;
            cnt_next   = '0;
            state_next = srtq_pkg::ST_SWEEP;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

    // assertions
    `ASSERT_IMPLY(a_enq_advances, clk, rst_n,
        (state_reg == srtq_pkg::ST_LOOK && out_free && req_reg == srtq_pkg::REQ_ENQ
         && enq_hit && !cfg_valid) |=> (wpos_reg == $past(wpos_reg) + 64'd1))
    `ASSERT_IMPLY(a_look_write_free, clk, rst_n,
        (stamp_we && state_reg == srtq_pkg::ST_LOOK) |-> out_free)
    `ASSERT_IMPLY(a_sweep_bound, clk, rst_n,
        (state_reg == srtq_pkg::ST_SWEEP) |-> (cnt_reg <= mask_reg))
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n,
        (wpos_reg - rpos_reg) <= (mask_ext + 64'd1))

endmodule
